// File: rtl/core/t8e_pkg.sv
// ----------------------------------------------------------------------------
// t8e_pkg
// Types and constants shared by the execute unit of the 8-bit machine.
// ----------------------------------------------------------------------------
package t8e_pkg;

	localparam logic [15:0] HALT_PC = 16'hffff;

	// dense opcode numbering
	typedef enum logic [5:0] {
		OP_NOP  = 6'd0,
		OP_MOV  = 6'd1,
		OP_LOD  = 6'd2,
		OP_OUT  = 6'd3,
		OP_INP  = 6'd4,
		OP_JNZA = 6'd5,
		OP_ADD  = 6'd6,
		OP_ADDI = 6'd7,
		OP_SUB  = 6'd8,
		OP_SUBI = 6'd9,
		OP_NAD  = 6'd10,
		OP_NADI = 6'd11,
		OP_NOR  = 6'd12,
		OP_NORI = 6'd13,
		OP_CMP  = 6'd14,
		OP_CMPI = 6'd15,
		OP_JZRA = 6'd16,
		OP_LDRA = 6'd17,
		OP_WTRA = 6'd18,
		OP_JMPA = 6'd19,
		OP_JEQA = 6'd20,
		OP_JNQA = 6'd21,
		OP_JNZB = 6'd22,
		OP_JZRB = 6'd23,
		OP_JMPB = 6'd24,
		OP_JEQB = 6'd25,
		OP_JNQB = 6'd26,
		OP_LDRB = 6'd27,
		OP_WTRB = 6'd28,
		OP_JMPI = 6'd29,
		OP_JEQI = 6'd30,
		OP_JNQI = 6'd31,
		OP_JZRI = 6'd32,
		OP_JNZI = 6'd33
	} opcode_t;

	// request kinds
	localparam logic REQ_EXEC    = 1'b0;
	localparam logic REQ_PRELOAD = 1'b1;

	typedef logic [7:0] gpr_t;
	typedef gpr_t [3:0] regfile_t;

	typedef struct packed {
		logic req_type;
		logic [5:0] opcode;
		logic [1:0] dest_reg;
		logic [1:0] src_reg;
		logic [7:0] imm8;
		logic [15:0] imm16;
		logic [7:0] io_in_data;
		logic [15:0] preload_addr;
		logic [7:0] preload_byte;
	} req_t;

	typedef struct packed {
		logic [15:0] next_pc;
		logic halted;
		logic flag_zero;
		logic flag_equal;
		logic io_write_valid;
		logic io_read_valid;
		logic [15:0] io_address;
		logic [7:0] io_out_data;
		logic [7:0] reg_zero;
		logic [7:0] reg_one;
		logic [7:0] reg_two;
		logic [7:0] reg_three;
	} res_t;

	typedef struct packed {
		logic equal;
		logic halt;
		logic zero;
	} flags_t;

	typedef struct packed {
		logic wr;
		logic rd;
		logic [15:0] addr;
		logic [7:0] wdata;
	} mem_cmd_t;

	typedef struct packed {
		logic io_w;
		logic io_r;
		logic [15:0] io_addr;
		logic [7:0] io_data;
	} io_info_t;

	typedef struct packed {
		regfile_t regs;
		logic [15:0] pc;
		flags_t flags;
		io_info_t io;
		logic ld;
		logic [1:0] ld_dst;
		mem_cmd_t mem;
	} exec_out_t;

endpackage

// File: rtl/core/t8e_if.sv
// ----------------------------------------------------------------------------
// t8e request and result channels
// Valid/ready channels carrying one request or one result per transfer.
// ----------------------------------------------------------------------------
interface t8e_req_if import t8e_pkg::*;;
	logic valid;
	logic ready;
	req_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface t8e_res_if import t8e_pkg::*;;
	logic valid;
	logic ready;
	res_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// File: rtl/core/t8e_dmem.sv
// ----------------------------------------------------------------------------
// t8e_dmem
// Byte-wide data memory with registered read and a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module t8e_dmem import t8e_pkg::*; #(
	parameter int MEM_DEPTH = 65536
) (
	input  logic clk,
	input  logic arst_n,
	input  mem_cmd_t cmd,
	output logic busy,
	output logic [7:0] rdata
);

	localparam int AW = $clog2(MEM_DEPTH);
	localparam bit POW2 = (MEM_DEPTH & (MEM_DEPTH - 1)) == 0;
	localparam longint RECIP_L = ((64'd1 << 32) + MEM_DEPTH - 1) / MEM_DEPTH;
	localparam logic [32:0] RECIP = RECIP_L[32:0];
	localparam logic [AW-1:0] LAST = AW'(MEM_DEPTH - 1);

	logic [7:0] mem [MEM_DEPTH];
	logic [AW-1:0] clr_idx_q;
	logic clr_busy_q;
	logic [AW-1:0] idx;
	logic [48:0] prod;
	logic [15:0] quot;
	logic [31:0] rem;

	// address reduced modulo the depth
	always_comb begin
		prod = 49'(cmd.addr) * 49'(RECIP);
		quot = prod[47:32];
		rem = 32'(cmd.addr) - 32'(quot) * 32'(MEM_DEPTH);
		if (POW2) begin
			idx = cmd.addr[AW-1:0];
		end else begin
			idx = rem[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == LAST) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_idx_q] <= 8'h00;
		end else if (cmd.wr) begin
			mem[idx] <= cmd.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata <= mem[idx];
		end
	end

	assign busy = clr_busy_q;

endmodule

// File: rtl/core/t8e_exec.sv
// ----------------------------------------------------------------------------
// t8e_exec
// Combinational execute: alu, compare, branch and memory command for one item.
// ----------------------------------------------------------------------------
module t8e_exec import t8e_pkg::*; #(
	parameter int INSTR_BYTES = 4
) (
	input  req_t item,
	input  regfile_t regs,
	input  logic [15:0] pc,
	input  flags_t flags,
	output exec_out_t res
);

	localparam logic [15:0] PC_STEP = 16'(INSTR_BYTES);

	logic [7:0] a;
	logic [7:0] b;
	logic [15:0] ar;
	logic [15:0] br;
	logic take;
	logic [15:0] target;

	assign a = regs[item.dest_reg];
	assign b = regs[item.src_reg];
	assign ar = {regs[1], regs[0]};
	assign br = {regs[3], regs[2]};

	always_comb begin
		res = '0;
		res.regs = regs;
		res.pc = pc;
		res.flags = flags;
		res.ld_dst = item.dest_reg;
		take = 1'b0;
		target = '0;
		if (!flags.halt) begin
			if (item.req_type == REQ_PRELOAD) begin
				res.mem.wr = 1'b1;
				res.mem.addr = item.preload_addr;
				res.mem.wdata = item.preload_byte;
			end else begin
				case (opcode_t'(item.opcode))
					OP_NOP: begin end
					OP_MOV: res.regs[item.dest_reg] = b;
					OP_LOD: res.regs[item.dest_reg] = item.imm8;
					OP_OUT: begin
						res.io.io_w = 1'b1;
						res.io.io_addr = ar;
						res.io.io_data = a;
					end
					OP_INP: begin
						res.io.io_r = 1'b1;
						res.io.io_addr = ar;
						res.regs[item.dest_reg] = item.io_in_data;
					end
					OP_ADD:  res.regs[item.dest_reg] = a + b;
					OP_ADDI: res.regs[item.dest_reg] = a + item.imm8;
					OP_SUB:  res.regs[item.dest_reg] = a - b;
					OP_SUBI: res.regs[item.dest_reg] = a - item.imm8;
					OP_NAD:  res.regs[item.dest_reg] = ~(a & b);
					OP_NADI: res.regs[item.dest_reg] = ~(a & item.imm8);
					OP_NOR:  res.regs[item.dest_reg] = ~(a | b);
					OP_NORI: res.regs[item.dest_reg] = ~(a | item.imm8);
					OP_CMP, OP_CMPI: begin
						res.flags = '0;
						res.flags.equal = (item.opcode == OP_CMP) ? (a == b) :
							(a == item.imm8);
						res.flags.zero = (a == 8'h00);
					end
					OP_LDRA, OP_LDRB: begin
						res.ld = 1'b1;
						res.mem.rd = 1'b1;
						res.mem.addr = (item.opcode == OP_LDRA) ? ar : br;
					end
					OP_WTRA, OP_WTRB: begin
						res.mem.wr = 1'b1;
						res.mem.addr = (item.opcode == OP_WTRA) ? ar : br;
						res.mem.wdata = a;
					end
					OP_JNZA: begin take = !flags.zero;  target = ar; end
					OP_JZRA: begin take = flags.zero;   target = ar; end
					OP_JMPA: begin take = 1'b1;         target = ar; end
					OP_JEQA: begin take = flags.equal;  target = ar; end
					OP_JNQA: begin take = !flags.equal; target = ar; end
					OP_JNZB: begin take = !flags.zero;  target = br; end
					OP_JZRB: begin take = flags.zero;   target = br; end
					OP_JMPB: begin take = 1'b1;         target = br; end
					OP_JEQB: begin take = flags.equal;  target = br; end
					OP_JNQB: begin take = !flags.equal; target = br; end
					OP_JMPI: begin take = 1'b1;         target = item.imm16; end
					OP_JEQI: begin take = flags.equal;  target = item.imm16; end
					OP_JNQI: begin take = !flags.equal; target = item.imm16; end
					OP_JZRI: begin take = flags.zero;   target = item.imm16; end
					OP_JNZI: begin take = !flags.zero;  target = item.imm16; end
					default: res.flags.halt = 1'b1;
				endcase
				res.pc = take ? target : pc + PC_STEP;
				if (res.pc == HALT_PC) begin
					res.flags.halt = 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/core/tiny_8bit_cpu_execute_unit.sv
// ----------------------------------------------------------------------------
// tiny_8bit_cpu_execute_unit
// Execute unit of an 8-bit, four-register machine with its own data memory.
// ----------------------------------------------------------------------------
// One request is taken per clock cycle, loads included, while the result side
// keeps up and the memory is not being cleared. Its result passes through the
// input register, then the result register. The data memory is a synchronous
// RAM with a registered read: a load reads it as the item leaves the input
// register, and the returned byte is forwarded straight into the register file
// view of the next item, so dependent instructions issue back to back. After
// reset the unit zeroes the data memory, one byte per cycle, and takes no
// request until that sweep is done. Once the halt flag is set, requests are
// still taken and answered with the frozen state.
module tiny_8bit_cpu_execute_unit import t8e_pkg::*; #(
	parameter int MEM_DEPTH = 65536,
	parameter int INSTR_BYTES = 4
) (
	input  logic clk,
	input  logic arst_n,
	t8e_req_if.sink req,
	t8e_res_if.source res
);

	// input register
	req_t item_s1;
	logic valid_s1;
	// result register: only the i/o fields, the rest is live state
	io_info_t io_s2;
	logic valid_s2;

	// architectural state
	regfile_t regs_q;
	logic [15:0] pc_q;
	flags_t flags_q;
	// load whose byte sits in the memory read register
	logic ld_pend_q;
	logic [1:0] ld_dst_q;

	regfile_t regs_eff;
	exec_out_t ex;
	mem_cmd_t mem_cmd;
	logic mem_busy;
	logic [7:0] mem_rdata;
	logic advance;

	// item moves from the input register to the result register
	assign advance = valid_s1 && (!valid_s2 || res.ready);
	assign req.ready = !mem_busy && (!valid_s1 || advance);

	// forward a pending load byte over the stored register
	always_comb begin
		regs_eff = regs_q;
		if (ld_pend_q) begin
			regs_eff[ld_dst_q] = mem_rdata;
		end
	end

	t8e_exec #(
		.INSTR_BYTES(INSTR_BYTES)
	) u_exec (
		.item(item_s1),
		.regs(regs_eff),
		.pc(pc_q),
		.flags(flags_q),
		.res(ex)
	);

	// memory only acts on the cycle the item advances, so read data holds
	// while the result is stalled
	always_comb begin
		mem_cmd = ex.mem;
		mem_cmd.wr = ex.mem.wr && advance;
		mem_cmd.rd = ex.mem.rd && advance;
	end

	t8e_dmem #(
		.MEM_DEPTH(MEM_DEPTH)
	) u_dmem (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(mem_cmd),
		.busy(mem_busy),
		.rdata(mem_rdata)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.payload;
		end
	end

	// state update and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			regs_q <= '0;
			pc_q <= '0;
			flags_q <= '0;
			ld_pend_q <= 1'b0;
			ld_dst_q <= '0;
			io_s2 <= '0;
		end else begin
			if (advance) begin
				valid_s2 <= 1'b1;
				regs_q <= ex.regs;
				pc_q <= ex.pc;
				flags_q <= ex.flags;
				ld_pend_q <= ex.ld;
				ld_dst_q <= ex.ld_dst;
				io_s2 <= ex.io;
			end else if (res.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// result fields: state stays frozen until the result transfer completes
	assign res.valid = valid_s2;
	always_comb begin
		res.payload.next_pc = pc_q;
		res.payload.halted = flags_q.halt;
		res.payload.flag_zero = flags_q.zero;
		res.payload.flag_equal = flags_q.equal;
		res.payload.io_write_valid = io_s2.io_w;
		res.payload.io_read_valid = io_s2.io_r;
		res.payload.io_address = io_s2.io_addr;
		res.payload.io_out_data = io_s2.io_data;
		res.payload.reg_zero = regs_eff[0];
		res.payload.reg_one = regs_eff[1];
		res.payload.reg_two = regs_eff[2];
		res.payload.reg_three = regs_eff[3];
	end

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 8-bit execute unit. A scoreboard class keeps its
// own copy of registers, flags, pc and data memory, predicts each result from
// the accepted requests and checks every result transfer field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import t8e_pkg::*;

	localparam int MEM_DEPTH = 65536;
	localparam int INSTR_BYTES = 4;
	// the unit clears its memory after reset, so allow several of those passes
	localparam int STALL_LIMIT = 4 * MEM_DEPTH;
	localparam int RANDOM_ITEMS = 1600;
	localparam int POST_HALT_ITEMS = 20;
	localparam int MAX_PRINTED = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// set while a stretch runs with both sides streaming flat out
	bit no_idle = 1'b0;
	int stall_cycles = 0;

	t8e_req_if req_ch();
	t8e_res_if res_ch();

	tiny_8bit_cpu_execute_unit #(
		.MEM_DEPTH(MEM_DEPTH),
		.INSTR_BYTES(INSTR_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch)
	);

	// predicts the machine state after each accepted request and holds the
	// results still owed by the unit, oldest first
	class exec_result_board;
		logic [15:0] pc;
		flags_t flags;
		regfile_t regs;
		logic [7:0] data_mem [int];
		res_t pending_results [$];
		int errors;
		int seen;

		function new();
			pc = '0;
			flags = '0;
			regs = '0;
			errors = 0;
			seen = 0;
		endfunction

		// never-written bytes read as zero after the clearing pass
		function logic [7:0] mem_byte(logic [15:0] addr);
			int idx;
			idx = int'(addr) % MEM_DEPTH;
			return data_mem.exists(idx) ? data_mem[idx] : 8'h00;
		endfunction

		function logic [15:0] pair_a();
			return {regs[1], regs[0]};
		endfunction

		function logic [15:0] pair_b();
			return {regs[3], regs[2]};
		endfunction

		// works on copies of the state; only writes them back when commit is set
		function res_t run_instruction(req_t r, bit commit);
			logic [15:0] p;
			flags_t f;
			regfile_t g;
			logic [15:0] ar;
			logic [15:0] br;
			logic [15:0] target;
			logic [7:0] a;
			logic [7:0] b;
			logic [7:0] other;
			logic take;
			res_t o;
			p = pc;
			f = flags;
			g = regs;
			o = '0;
			if (!f.halt) begin
				if (r.req_type == REQ_PRELOAD) begin
					if (commit)
						data_mem[int'(r.preload_addr) % MEM_DEPTH] = r.preload_byte;
				end else begin
					ar = {g[1], g[0]};
					br = {g[3], g[2]};
					a = g[r.dest_reg];
					b = g[r.src_reg];
					take = 1'b0;
					target = '0;
					case (r.opcode)
						OP_NOP: ;
						OP_MOV: g[r.dest_reg] = b;
						OP_LOD: g[r.dest_reg] = r.imm8;
						OP_OUT: begin
							o.io_write_valid = 1'b1;
							o.io_address = ar;
							o.io_out_data = a;
						end
						OP_INP: begin
							o.io_read_valid = 1'b1;
							o.io_address = ar;
							g[r.dest_reg] = r.io_in_data;
						end
						OP_ADD: g[r.dest_reg] = a + b;
						OP_ADDI: g[r.dest_reg] = a + r.imm8;
						OP_SUB: g[r.dest_reg] = a - b;
						OP_SUBI: g[r.dest_reg] = a - r.imm8;
						OP_NAD: g[r.dest_reg] = ~(a & b);
						OP_NADI: g[r.dest_reg] = ~(a & r.imm8);
						OP_NOR: g[r.dest_reg] = ~(a | b);
						OP_NORI: g[r.dest_reg] = ~(a | r.imm8);
						OP_CMP, OP_CMPI: begin
							other = (r.opcode == OP_CMP) ? b : r.imm8;
							f = '0;
							f.equal = (a == other);
							f.zero = (a == 8'h00);
						end
						OP_LDRA: g[r.dest_reg] = mem_byte(ar);
						OP_WTRA: if (commit) data_mem[int'(ar) % MEM_DEPTH] = a;
						OP_LDRB: g[r.dest_reg] = mem_byte(br);
						OP_WTRB: if (commit) data_mem[int'(br) % MEM_DEPTH] = a;
						OP_JNZA: begin take = !f.zero; target = ar; end
						OP_JZRA: begin take = f.zero; target = ar; end
						OP_JMPA: begin take = 1'b1; target = ar; end
						OP_JEQA: begin take = f.equal; target = ar; end
						OP_JNQA: begin take = !f.equal; target = ar; end
						OP_JNZB: begin take = !f.zero; target = br; end
						OP_JZRB: begin take = f.zero; target = br; end
						OP_JMPB: begin take = 1'b1; target = br; end
						OP_JEQB: begin take = f.equal; target = br; end
						OP_JNQB: begin take = !f.equal; target = br; end
						OP_JMPI: begin take = 1'b1; target = r.imm16; end
						OP_JEQI: begin take = f.equal; target = r.imm16; end
						OP_JNQI: begin take = !f.equal; target = r.imm16; end
						OP_JZRI: begin take = f.zero; target = r.imm16; end
						OP_JNZI: begin take = !f.zero; target = r.imm16; end
						default: f.halt = 1'b1;
					endcase
					p = take ? target : p + 16'(INSTR_BYTES);
					if (p == HALT_PC)
						f.halt = 1'b1;
				end
			end
			o.next_pc = p;
			o.halted = f.halt;
			o.flag_zero = f.zero;
			o.flag_equal = f.equal;
			o.reg_zero = g[0];
			o.reg_one = g[1];
			o.reg_two = g[2];
			o.reg_three = g[3];
			if (commit) begin
				pc = p;
				flags = f;
				regs = g;
			end
			return o;
		endfunction

		function void take_request(req_t r);
			pending_results.push_back(run_instruction(r, 1'b1));
		endfunction

		task report(string what);
			if (errors < MAX_PRINTED)
				$display("[%0t] mismatch on result %0d: %s", $realtime, seen, what);
			errors++;
		endtask

		task check_field(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report($sformatf("%s got %h want %h", name, got, want));
		endtask

		task match_result(res_t got);
			res_t want;
			if (pending_results.size() == 0) begin
				report("result with nothing outstanding");
			end else begin
				want = pending_results.pop_front();
				check_field("next_pc", got.next_pc, want.next_pc);
				check_field("halted", 16'(got.halted), 16'(want.halted));
				check_field("flag_zero", 16'(got.flag_zero), 16'(want.flag_zero));
				check_field("flag_equal", 16'(got.flag_equal), 16'(want.flag_equal));
				check_field("io_write_valid", 16'(got.io_write_valid),
					16'(want.io_write_valid));
				check_field("io_read_valid", 16'(got.io_read_valid),
					16'(want.io_read_valid));
				check_field("io_address", got.io_address, want.io_address);
				check_field("io_out_data", 16'(got.io_out_data), 16'(want.io_out_data));
				check_field("reg_zero", 16'(got.reg_zero), 16'(want.reg_zero));
				check_field("reg_one", 16'(got.reg_one), 16'(want.reg_one));
				check_field("reg_two", 16'(got.reg_two), 16'(want.reg_two));
				check_field("reg_three", 16'(got.reg_three), 16'(want.reg_three));
			end
			seen++;
		endtask
	endclass

	exec_result_board board = new();

	// 20 unit period, low phase first
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// every field filled at random, so every input bit toggles over the run
	function automatic req_t rand_item();
		req_t r;
		r.req_type = 1'($urandom);
		r.opcode = 6'($urandom);
		r.dest_reg = 2'($urandom);
		r.src_reg = 2'($urandom);
		r.imm8 = 8'($urandom);
		r.imm16 = 16'($urandom);
		r.io_in_data = 8'($urandom);
		r.preload_addr = 16'($urandom);
		r.preload_byte = 8'($urandom);
		return r;
	endfunction

	function automatic req_t exec_req(opcode_t op, logic [1:0] d, logic [1:0] s,
			logic [7:0] i8, logic [15:0] i16);
		req_t r;
		r = rand_item();
		r.req_type = REQ_EXEC;
		r.opcode = op;
		r.dest_reg = d;
		r.src_reg = s;
		r.imm8 = i8;
		r.imm16 = i16;
		return r;
	endfunction

	function automatic req_t preload_req(logic [15:0] addr, logic [7:0] data);
		req_t r;
		r = rand_item();
		r.req_type = REQ_PRELOAD;
		r.preload_addr = addr;
		r.preload_byte = data;
		return r;
	endfunction

	// a well-formed program step with random content: known opcodes only,
	// preloads aimed mostly where the address pairs point, and never a step
	// that would halt the machine before the closing part
	function automatic req_t program_step();
		req_t r;
		res_t trial;
		r = rand_item();
		r.req_type = ($urandom_range(0, 99) < 15) ? REQ_PRELOAD : REQ_EXEC;
		r.opcode = 6'($urandom_range(0, int'(OP_JNZI)));
		if ($urandom_range(0, 9) == 0)
			r.imm8 = 8'h00;
		case ($urandom_range(0, 2))
			0: r.preload_addr = board.pair_a();
			1: r.preload_addr = board.pair_b();
			default: ;
		endcase
		trial = board.run_instruction(r, 1'b0);
		if (trial.halted) begin
			// a word-aligned target can never step onto the halt address
			r.req_type = REQ_EXEC;
			r.opcode = OP_JMPI;
			r.imm16 = 16'($urandom) & 16'hfffc;
		end
		return r;
	endfunction

	// hold the request until the transfer, idling beforehand now and then;
	// valid is left high so that a back-to-back request keeps it asserted
	task automatic send(req_t r);
		while (!no_idle && $urandom_range(0, 99) < 26) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.payload <= r;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		board.take_request(r);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (board.pending_results.size() != 0)
			@(posedge clk);
	endtask

	// result side back-pressure
	always @(posedge clk)
		res_ch.ready <= arst_n && (no_idle || $urandom_range(0, 99) >= 26);

	always @(posedge clk)
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
			board.match_result(res_ch.payload);

	// ends the run if neither channel moves a transfer for too long
	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		req_t r;
		int variant;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		res_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed part: both ends of memory, wrapping arithmetic, every
		// logic op, compare with equal and zero, taken and untaken jumps
		send(preload_req(HALT_PC, 8'ha5));
		send(preload_req(16'h0000, 8'h5a));
		send(exec_req(OP_LOD, 2'd0, 2'd0, 8'hff, 16'h0000));
		send(exec_req(OP_LOD, 2'd1, 2'd0, 8'hff, 16'h0000));
		send(exec_req(OP_LDRA, 2'd3, 2'd0, 8'h00, 16'h0000));
		send(exec_req(OP_OUT, 2'd3, 2'd0, 8'h00, 16'h0000));
		r = exec_req(OP_INP, 2'd2, 2'd0, 8'h00, 16'h0000);
		r.io_in_data = 8'hff;
		send(r);
		send(exec_req(OP_ADD, 2'd0, 2'd2, 8'h00, 16'h0000));
		send(exec_req(OP_ADDI, 2'd1, 2'd0, 8'h01, 16'h0000));
		send(exec_req(OP_SUBI, 2'd1, 2'd0, 8'h01, 16'h0000));
		send(exec_req(OP_SUB, 2'd2, 2'd3, 8'h00, 16'h0000));
		send(exec_req(OP_NAD, 2'd0, 2'd1, 8'h00, 16'h0000));
		send(exec_req(OP_NADI, 2'd2, 2'd0, 8'hff, 16'h0000));
		send(exec_req(OP_NOR, 2'd3, 2'd0, 8'h00, 16'h0000));
		send(exec_req(OP_NORI, 2'd1, 2'd0, 8'h00, 16'h0000));
		send(exec_req(OP_MOV, 2'd0, 2'd1, 8'h00, 16'h0000));
		send(exec_req(OP_LOD, 2'd2, 2'd0, 8'h00, 16'h0000));
		send(exec_req(OP_LOD, 2'd3, 2'd0, 8'h00, 16'h0000));
		send(exec_req(OP_LDRB, 2'd0, 2'd0, 8'h00, 16'h0000));
		send(exec_req(OP_CMP, 2'd3, 2'd2, 8'h00, 16'h0000));
		// pc wraps from the top of the address space back to zero
		send(exec_req(OP_JZRI, 2'd0, 2'd0, 8'h00, 16'hfffc));
		send(exec_req(OP_NOP, 2'd0, 2'd0, 8'h00, 16'h0000));
		send(exec_req(OP_CMPI, 2'd0, 2'd0, 8'h5a, 16'h0000));
		send(exec_req(OP_JNQI, 2'd0, 2'd0, 8'h00, 16'h1234));
		send(exec_req(OP_JEQI, 2'd0, 2'd0, 8'h00, 16'h0200));
		send(exec_req(OP_WTRB, 2'd1, 2'd0, 8'h00, 16'h0000));

		// let the unit run dry before streaming the random part
		drain();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			no_idle = (i >= 700 && i < 1000);
			send(program_step());
		end
		no_idle = 1'b0;

		// closing part: halt the machine one of three ways, then check that
		// nothing moves any more
		variant = $urandom_range(0, 2);
		case (variant)
			0: begin
				r = rand_item();
				r.req_type = REQ_EXEC;
				r.opcode = 6'($urandom_range(int'(OP_JNZI) + 1, 63));
				send(r);
			end
			1: send(exec_req(OP_JMPI, 2'd0, 2'd0, 8'h00, HALT_PC));
			default: begin
				// pc steps onto the halt address by plain advance
				send(exec_req(OP_JMPI, 2'd0, 2'd0, 8'h00, 16'hfff7));
				send(exec_req(OP_NOP, 2'd0, 2'd0, 8'h00, 16'h0000));
				send(exec_req(OP_NOP, 2'd0, 2'd0, 8'h00, 16'h0000));
			end
		endcase
		for (int i = 0; i < POST_HALT_ITEMS; i++)
			send(rand_item());

		drain();
		// room for any stray result to show up
		repeat (10) @(posedge clk);
		if (board.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: files.f
rtl/core/t8e_pkg.sv
rtl/core/t8e_if.sv
rtl/core/t8e_dmem.sv
rtl/core/t8e_exec.sv
rtl/core/tiny_8bit_cpu_execute_unit.sv
test/tb_top.sv
